// ----- src/dsh_pkg.sv -----
// shared types, codes and the half-step pattern table for the dual stepper sequencer
package dsh_pkg;

	// default amount width and derived run-length limits
	localparam int AMOUNT_WIDTH_DEF = 10;
	localparam int CYCLES_W         = 18;
	localparam int CYCLES_MAX       = (1 << CYCLES_W) - 1;
	localparam int DELAY_W          = 16;
	localparam int SCALE_W          = 8;

	// register defaults
	localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd200;
	localparam logic [SCALE_W-1:0] DSCALE_RESET = 8'd25;
	localparam logic [SCALE_W-1:0] ASCALE_RESET = 8'd15;

	// configuration register indexes
	localparam logic [1:0] REG_DELAY  = 2'd0;
	localparam logic [1:0] REG_DSCALE = 2'd1;
	localparam logic [1:0] REG_ASCALE = 2'd2;

	// request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// motions
	localparam logic [1:0] MOT_FWD   = 2'd0;
	localparam logic [1:0] MOT_BWD   = 2'd1;
	localparam logic [1:0] MOT_LEFT  = 2'd2;
	localparam logic [1:0] MOT_RIGHT = 2'd3;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_ticks;
		logic [SCALE_W-1:0] dist_scale;
		logic [SCALE_W-1:0] ang_scale;
	} dsh_cfg_t;

	typedef struct packed {
		logic       done;
		logic       busy;
		logic [3:0] right;
		logic [3:0] left;
	} dsh_res_t;

	// half-step coil pattern for phase p
	function automatic logic [3:0] half_pattern(input logic [2:0] p);
		logic [3:0] pat;
		case (p)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

endpackage

// ----- src/dual_stepper_halfstep_sequencer_unit.sv -----
// Dual stepper half-step sequencer: one request beat in, one status beat out. Each beat
// (tick, start or stop) is captured in an input register and applied to the sequencer
// state once the output register is free; coil drive and busy/done flags land in the
// output register at that same edge. A new beat is taken every cycle as long as the
// output side keeps up; throughput is set by the single state update per cycle. A tick
// in a run does one delay decrement, one single-coil write on both motors, or ends it.
module dual_stepper_halfstep_sequencer_unit #(
	parameter int AMOUNT_WIDTH = dsh_pkg::AMOUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [((2 + AMOUNT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // motion[1:0], amount,
	                                                                // zero pad
	input  logic [1:0]             s_tuser,   // req_type[1:0]
	// status stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // left_coils[3:0], right_coils[3:0],
	                                          // busy_res, done_res, zero pad
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	logic                    valid_s1;
	logic [1:0]              req_s1, motion_s1;
	logic [AMOUNT_WIDTH-1:0] amount_s1;
	logic                    advance, accept;
	logic                    m_valid_q;
	dsh_pkg::dsh_res_t       res, res_q;
	dsh_pkg::dsh_cfg_t       cfg_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks <= dsh_pkg::DELAY_RESET;
			cfg_q.dist_scale  <= dsh_pkg::DSCALE_RESET;
			cfg_q.ang_scale   <= dsh_pkg::ASCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dsh_pkg::REG_DELAY:  cfg_q.delay_ticks <= cfg_data;
				dsh_pkg::REG_DSCALE: cfg_q.dist_scale  <= cfg_data[7:0];
				dsh_pkg::REG_ASCALE: cfg_q.ang_scale   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= s_tuser;
			motion_s1 <= s_tdata[1:0];
			amount_s1 <= s_tdata[AMOUNT_WIDTH+1:2];
		end
	end

	dsh_core #(
		.AMOUNT_WIDTH(AMOUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.req    (req_s1),
		.motion (motion_s1),
		.amount (amount_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, res_q.done, res_q.busy, res_q.right, res_q.left};

	// a finished run is never reported as still busy
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.done |-> !res_q.busy)
		else $error("done and busy both set on a status beat");

	// input side stalls only while a beat waits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("request stream stalled with empty input register");

	// every processed beat lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q)
		else $error("processed beat lost before the output register");

endmodule

// ----- src/dsh_core.sv -----
// sequencer state and the per-item update logic
module dsh_core #(
	parameter int AMOUNT_WIDTH = dsh_pkg::AMOUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [1:0]              req,
	input  logic [1:0]              motion,
	input  logic [AMOUNT_WIDTH-1:0] amount,
	input  dsh_pkg::dsh_cfg_t       cfg,
	output dsh_pkg::dsh_res_t       res
);

	localparam int PROD_W = dsh_pkg::SCALE_W + AMOUNT_WIDTH;

	logic [3:0]                     left_q, right_q, left_d, right_d;
	logic [2:0]                     phase_q, phase_d;
	logic [1:0]                     coil_q, coil_d;
	logic [dsh_pkg::CYCLES_W-1:0]   cycles_q, cycles_d, total;
	logic [dsh_pkg::DELAY_W-1:0]    delay_q, delay_d;
	logic [1:0]                     motion_q, motion_d;
	logic                           running_q, running_d, done_d;
	logic [PROD_W-1:0]              prod;
	logic [31:0]                    prod_ext;
	logic [dsh_pkg::SCALE_W-1:0]    scale;
	logic [2:0]                     pl, pr;
	logic [3:0]                     mask;

	// run length, saturated to the counter width
	always_comb begin
		scale    = (motion == dsh_pkg::MOT_FWD || motion == dsh_pkg::MOT_BWD) ?
			cfg.dist_scale : cfg.ang_scale;
		prod     = PROD_W'(scale) * PROD_W'(amount);
		prod_ext = 32'(prod);
		if (prod_ext > 32'(dsh_pkg::CYCLES_MAX)) begin
			total = '1;
		end else begin
			total = prod_ext[dsh_pkg::CYCLES_W-1:0];
		end
	end

	// phase for each motor, mirrored phase is 7 - p
	always_comb begin
		case (motion_q)
			dsh_pkg::MOT_FWD: begin
				pl = phase_q;
				pr = phase_q;
			end
			dsh_pkg::MOT_BWD: begin
				pl = ~phase_q;
				pr = ~phase_q;
			end
			dsh_pkg::MOT_LEFT: begin
				pl = phase_q;
				pr = ~phase_q;
			end
			default: begin
				pl = ~phase_q;
				pr = phase_q;
			end
		endcase
		mask = 4'b0001 << coil_q;
	end

	// next state for one item
	always_comb begin
		left_d    = left_q;
		right_d   = right_q;
		phase_d   = phase_q;
		coil_d    = coil_q;
		cycles_d  = cycles_q;
		delay_d   = delay_q;
		motion_d  = motion_q;
		running_d = running_q;
		done_d    = 1'b0;
		case (req)
			dsh_pkg::REQ_TICK: begin
				if (running_q) begin
					if (delay_q != '0) begin
						delay_d = delay_q - 1'b1;
					end else if (cycles_q == '0) begin
						running_d = 1'b0;
						done_d    = 1'b1;
						if (motion_q != dsh_pkg::MOT_FWD) begin
							left_d  = '0;
							right_d = '0;
						end
					end else begin
						left_d  = (left_q & ~mask) | (dsh_pkg::half_pattern(pl) & mask);
						right_d = (right_q & ~mask) | (dsh_pkg::half_pattern(pr) & mask);
						coil_d  = coil_q + 1'b1;
						if (coil_q == 2'd3) begin
							phase_d = phase_q + 1'b1;
							if (phase_q == 3'd7) begin
								cycles_d = cycles_q - 1'b1;
							end
						end
						delay_d = (cfg.delay_ticks == '0) ? '0 : cfg.delay_ticks - 1'b1;
					end
				end
			end
			dsh_pkg::REQ_START: begin
				if (!running_q) begin
					motion_d  = motion;
					phase_d   = '0;
					coil_d    = '0;
					delay_d   = '0;
					cycles_d  = total;
					running_d = (total != '0);
					if (total == '0) begin
						done_d = 1'b1;
						if (motion != dsh_pkg::MOT_FWD) begin
							left_d  = '0;
							right_d = '0;
						end
					end
				end
			end
			dsh_pkg::REQ_STOP: begin
				left_d    = '0;
				right_d   = '0;
				running_d = 1'b0;
				done_d    = running_q;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			right_q   <= '0;
			phase_q   <= '0;
			coil_q    <= '0;
			cycles_q  <= '0;
			delay_q   <= '0;
			motion_q  <= dsh_pkg::MOT_FWD;
			running_q <= 1'b0;
		end else if (advance) begin
			left_q    <= left_d;
			right_q   <= right_d;
			phase_q   <= phase_d;
			coil_q    <= coil_d;
			cycles_q  <= cycles_d;
			delay_q   <= delay_d;
			motion_q  <= motion_d;
			running_q <= running_d;
		end
	end

	assign res.left  = left_d;
	assign res.right = right_d;
	assign res.busy  = running_d;
	assign res.done  = done_d;

endmodule

// ----- sim/dual_stepper_halfstep_sequencer_unit_tb.sv -----
// testbench for the dual stepper half-step sequencer: coil and status checks against a local model
module dual_stepper_halfstep_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW          = dsh_pkg::AMOUNT_WIDTH_DEF;
	localparam int S_W         = ((2 + AW + 7) / 8) * 8;
	localparam int M_W         = 16;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE      = 4;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	// half-step coil patterns, phase 0 to 7
	localparam logic [3:0] COIL_STEPS [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic [1:0]     s_tuser = dsh_pkg::REQ_TICK;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [1:0]     cfg_index = dsh_pkg::REG_DELAY;
	logic [15:0]    cfg_data = '0;

	dual_stepper_halfstep_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// local copy of the registers and the sequencer state
	logic [15:0] step_delay;
	logic [7:0]  dist_per_unit;
	logic [7:0]  turn_per_unit;
	logic [3:0]  left_now;
	logic [3:0]  right_now;
	logic [2:0]  phase_now;
	logic [1:0]  coil_now;
	logic [17:0] cycles_rem;
	logic [15:0] wait_ticks;
	logic [1:0]  run_motion;
	logic        run_on;

	dsh_pkg::dsh_res_t coil_status_q [$];
	int       mismatches = 0;
	int       burst_left = 0;
	int       hold_asked = 0;
	int       hold_granted = 0;
	int       hold_left = 0;
	int       sink_cycle = 0;

	// one single-coil write on both motors, then step coil and phase
	task automatic write_one_coil();
		logic [2:0] fwd_phase;
		logic [2:0] rev_phase;
		logic [2:0] lp;
		logic [2:0] rp;
		logic [3:0] mask;
		fwd_phase = phase_now;
		rev_phase = 3'd7 - phase_now;
		mask = 4'b0001 << coil_now;
		case (run_motion)
			dsh_pkg::MOT_FWD:  begin lp = fwd_phase; rp = fwd_phase; end
			dsh_pkg::MOT_BWD:  begin lp = rev_phase; rp = rev_phase; end
			dsh_pkg::MOT_LEFT: begin lp = fwd_phase; rp = rev_phase; end
			default:           begin lp = rev_phase; rp = fwd_phase; end
		endcase
		left_now  = (left_now & ~mask) | (COIL_STEPS[lp] & mask);
		right_now = (right_now & ~mask) | (COIL_STEPS[rp] & mask);
		coil_now = coil_now + 2'd1;
		if (coil_now == 2'd0) begin
			phase_now = phase_now + 3'd1;
			if (phase_now == 3'd0 && cycles_rem != 0)
				cycles_rem = cycles_rem - 18'd1;
		end
		wait_ticks = (step_delay == 16'd0) ? 16'd0 : step_delay - 16'd1;
	endtask

	// run end: all but forward drop the coils
	task automatic end_of_run();
		run_on = 1'b0;
		if (run_motion != dsh_pkg::MOT_FWD) begin
			left_now = 4'h0;
			right_now = 4'h0;
		end
	endtask

	// apply one request beat and give the status it produces
	task automatic sequencer_advance(input logic [1:0] kind, input logic [1:0] mot,
			input logic [AW-1:0] amt, output dsh_pkg::dsh_res_t status);
		logic   done;
		int     scale;
		longint total;
		done = 1'b0;
		case (kind)
			dsh_pkg::REQ_TICK: begin
				if (run_on) begin
					if (wait_ticks != 0)
						wait_ticks = wait_ticks - 16'd1;
					else if (cycles_rem == 0) begin
						end_of_run();
						done = 1'b1;
					end else
						write_one_coil();
				end
			end
			dsh_pkg::REQ_START: begin
				if (!run_on) begin
					scale = int'((mot == dsh_pkg::MOT_FWD || mot == dsh_pkg::MOT_BWD) ?
						dist_per_unit : turn_per_unit);
					total = longint'(scale) * longint'(amt);
					if (total > dsh_pkg::CYCLES_MAX)
						total = longint'(dsh_pkg::CYCLES_MAX);
					run_motion = mot;
					phase_now = 3'd0;
					coil_now = 2'd0;
					wait_ticks = 16'd0;
					cycles_rem = total[17:0];
					run_on = 1'b1;
					if (total == 0) begin
						end_of_run();
						done = 1'b1;
					end
				end
			end
			dsh_pkg::REQ_STOP: begin
				left_now = 4'h0;
				right_now = 4'h0;
				if (run_on) begin
					run_on = 1'b0;
					done = 1'b1;
				end
			end
			default: ;
		endcase
		status.left  = left_now;
		status.right = right_now;
		status.busy  = run_on;
		status.done  = done;
	endtask

	// offer one request beat, with random gaps between bursts
	task automatic send_request(input logic [1:0] kind, input logic [1:0] mot,
			input logic [AW-1:0] amt);
		dsh_pkg::dsh_res_t want;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_W - AW - 2){1'b0}}, amt, mot};
		do @(posedge clk); while (!s_tready);
		sequencer_advance(kind, mot, amt, want);
		coil_status_q.push_back(want);
	endtask

	// wait for the pipeline to drain, then write one register
	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		s_tvalid <= 1'b0;
		while (coil_status_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dsh_pkg::REG_DELAY:  step_delay = value;
			dsh_pkg::REG_DSCALE: dist_per_unit = value[7:0];
			dsh_pkg::REG_ASCALE: turn_per_unit = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [15:0] dly, input logic [7:0] dsc,
			input logic [7:0] asc);
		write_register(dsh_pkg::REG_DELAY, dly);
		write_register(dsh_pkg::REG_DSCALE, {8'h00, dsc});
		write_register(dsh_pkg::REG_ASCALE, {8'h00, asc});
	endtask

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	// status sink: checks each beat and stalls on its own pattern
	dsh_pkg::dsh_res_t sink_want;
	dsh_pkg::dsh_res_t sink_got;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sink_got = dsh_pkg::dsh_res_t'(m_tdata[9:0]);
			if (coil_status_q.size() == 0) begin
				mismatches++;
				$display("%0t: status beat with none expected, expected none, actual %0h",
					$time, sink_got);
			end else begin
				sink_want = coil_status_q.pop_front();
				compare_field("left_coils", sink_want.left, sink_got.left);
				compare_field("right_coils", sink_want.right, sink_got.right);
				compare_field("busy_res", sink_want.busy, sink_got.busy);
				compare_field("done_res", sink_want.done, sink_got.done);
			end
		end
		sink_cycle++;
		if (hold_left == 0 && hold_asked != hold_granted) begin
			hold_granted++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((sink_cycle / 97) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// reset register values, a short run with the default delay
	task automatic test_defaults();
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_BWD, AW'(1));
		send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
	endtask

	// zero-length runs for left, right and backward motion
	task automatic test_zero_runs();
		set_registers(16'd1, 8'd1, 8'd1);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_LEFT, '0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_RIGHT, '0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_BWD, '0);
	endtask

	// zero delay, requests that arrive mid-run, stop and tick while idle
	task automatic test_busy_requests();
		write_register(dsh_pkg::REG_DELAY, 16'd0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_FWD, '1);
		repeat (3) send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_BWD, '0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_RIGHT, AW'(5));
		send_request(REQ_RESERVED, dsh_pkg::MOT_LEFT, '1);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(REQ_RESERVED, dsh_pkg::MOT_RIGHT, '0);
	endtask

	// largest delay and scales
	task automatic test_register_extremes();
		set_registers(16'hFFFF, 8'hFF, 8'hFF);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_BWD, '1);
		repeat (2) send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_LEFT, AW'(512));
		repeat (2) send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
	endtask

	// random runs under one register setting
	task automatic run_random_phase(input int target);
		int             counted;
		int             pick;
		int             stop_odds;
		logic [1:0]     mot;
		logic [AW-1:0]  amt;
		counted = 0;
		while (counted < target) begin
			mot = 2'($urandom_range(0, 3));
			pick = $urandom_range(0, 99);
			if (pick < 75)
				amt = AW'($urandom_range(0, 1));
			else if (pick < 80)
				amt = AW'($urandom_range(2, 3));
			else
				amt = AW'($urandom_range(0, (1 << AW) - 1));
			pick = $urandom_range(0, 999);
			if (!run_on) begin
				if (pick < 800) begin
					send_request(dsh_pkg::REQ_START, mot, amt);
					counted++;
				end else if (pick < 880)
					send_request(dsh_pkg::REQ_STOP, mot, amt);
				else if (pick < 950)
					send_request(dsh_pkg::REQ_TICK, mot, amt);
				else
					send_request(REQ_RESERVED, mot, amt);
			end else begin
				stop_odds = (cycles_rem > 2) ? 40 : 8;
				if (pick < stop_odds) begin
					send_request(dsh_pkg::REQ_STOP, mot, amt);
					counted++;
				end else if (pick < stop_odds + 30)
					send_request(dsh_pkg::REQ_START, mot, amt);
				else if (pick < stop_odds + 60)
					send_request(REQ_RESERVED, mot, amt);
				else begin
					send_request(dsh_pkg::REQ_TICK, mot, amt);
					counted++;
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		set_registers(16'd1, 8'd1, 8'd1);
		run_random_phase(225);
		set_registers(16'd2, 8'd2, 8'd1);
		run_random_phase(225);
		set_registers(16'd0, 8'd1, 8'd2);
		run_random_phase(225);
		set_registers(16'd3, 8'd1, 8'd1);
		run_random_phase(225);
	endtask

	// long sink stall while requests keep coming
	task automatic test_backpressure();
		set_registers(16'd2, 8'd1, 8'd1);
		send_request(dsh_pkg::REQ_START, dsh_pkg::MOT_RIGHT, AW'(3));
		hold_asked++;
		repeat (40) send_request(dsh_pkg::REQ_TICK, dsh_pkg::MOT_FWD, '0);
		send_request(dsh_pkg::REQ_STOP, dsh_pkg::MOT_FWD, '0);
	endtask

	initial begin
		step_delay    = dsh_pkg::DELAY_RESET;
		dist_per_unit = dsh_pkg::DSCALE_RESET;
		turn_per_unit = dsh_pkg::ASCALE_RESET;
		left_now      = 4'h0;
		right_now     = 4'h0;
		phase_now     = 3'd0;
		coil_now      = 2'd0;
		cycles_rem    = '0;
		wait_ticks    = '0;
		run_motion    = dsh_pkg::MOT_FWD;
		run_on        = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_zero_runs();
		test_busy_requests();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();

		s_tvalid <= 1'b0;
		while (coil_status_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d status beats outstanding", coil_status_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
src/dsh_pkg.sv
src/dsh_core.sv
src/dual_stepper_halfstep_sequencer_unit.sv
sim/dual_stepper_halfstep_sequencer_unit_tb.sv
